@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the RTL of the decimal parser.
// No dependencies; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define ADP_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition implies another in the same cycle.
`define ADP_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

@@ rtl/core/adp_pkg.sv @@
// Shared widths and codes for the ASCII decimal number parser.
// No dependencies; used by the channel interfaces and the top level.
package adp_pkg;

  localparam int CH_W     = 8;
  localparam int VALUE_W  = 33;
  localparam int STATUS_W = 3;
  localparam int FAIL_W   = 16;
  localparam int TYPE_W   = 2;
  localparam int PHASE_W  = 2;
  localparam int CFG_AW   = 3;
  localparam int CFG_DW   = 32;

  // Parser phases
  localparam logic [PHASE_W-1:0] PH_SEEK   = 2'd0;
  localparam logic [PHASE_W-1:0] PH_SIGN   = 2'd1;
  localparam logic [PHASE_W-1:0] PH_DIGITS = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NOSTART  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NODIGIT  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW = 3'd3;
  localparam logic [STATUS_W-1:0] ST_RANGE    = 3'd4;

  // Target type codes
  localparam logic [TYPE_W-1:0] TT_U8  = 2'd0;
  localparam logic [TYPE_W-1:0] TT_U32 = 2'd1;
  localparam logic [TYPE_W-1:0] TT_S16 = 2'd2;

  // Register indexes
  localparam logic REG_TARGET_TYPE = 1'b0;

  localparam logic [FAIL_W-1:0] FAIL_MAX = 16'hFFFF;

  localparam logic [CH_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CH_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CH_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CH_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CH_W-1:0] CH_NINE  = 8'h39;

endpackage

@@ rtl/core/adp_if.sv @@
// Valid/ready channel interfaces for the decimal parser.
// Depends on adp_pkg for field widths.
interface adp_in_if;
  logic                        valid;
  logic                        ready;
  logic [adp_pkg::CH_W-1:0]    ch;
  logic                        at_end;

  modport source (output valid, output ch, output at_end, input ready);
  modport sink (input valid, input ch, input at_end, output ready);
endinterface

interface adp_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [adp_pkg::VALUE_W-1:0] value;
  logic [adp_pkg::STATUS_W-1:0]      status;
  logic [adp_pkg::FAIL_W-1:0]        fail_count;

  modport source (output valid, output value, output status, output fail_count,
                  input ready);
  modport sink (input valid, input value, input status, input fail_count,
                output ready);
endinterface

@@ rtl/core/ascii_decimal_number_parser.sv @@
// ASCII decimal number parser: a result word appears the cycle after its last character is taken.
// Throughput one character per cycle unless stalled; the multiply-by-ten-and-add path sets the cycle.
// One result register; a result word held off by the sink stalls input until it is taken.
// Synchronous active-low reset returns to seeking, clears the accumulator, the
// failure count and target_type (unsigned 8-bit).
// Depends on adp_pkg, adp_if and assert_macros.svh.
`include "assert_macros.svh"

module ascii_decimal_number_parser #(
  parameter int ACC_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  adp_in_if.sink                        in_chan,
  adp_out_if.source                     out_chan,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [adp_pkg::CFG_AW-1:0]    paddr,
  input  logic [adp_pkg::CFG_DW-1:0]    pwdata,
  output logic [adp_pkg::CFG_DW-1:0]    prdata,
  output logic                          pready
);

  localparam int PROD_W = ACC_BITS + 4;
  localparam int EXT_W  = (ACC_BITS > adp_pkg::VALUE_W) ? ACC_BITS : adp_pkg::VALUE_W;

  logic [adp_pkg::PHASE_W-1:0]  phase_r, phase_nxt;
  logic                         neg_r, neg_nxt;
  logic [ACC_BITS-1:0]          acc_r, acc_nxt;
  logic [adp_pkg::FAIL_W-1:0]   failures_r, failures_nxt;
  logic [adp_pkg::TYPE_W-1:0]   tgt_r;

  logic                         out_valid_r;
  logic [adp_pkg::VALUE_W-1:0]  value_r;
  logic [adp_pkg::STATUS_W-1:0] status_r;
  logic [adp_pkg::FAIL_W-1:0]   fail_cnt_r;

  logic                         in_fire;
  logic                         is_end, is_digit, is_space, is_sign;
  logic [3:0]                   digit_val;
  logic [PROD_W-1:0]            prod;
  logic                         ovf;
  logic [EXT_W-1:0]             acc_ext;
  logic [adp_pkg::STATUS_W-1:0] fin_status;
  logic [adp_pkg::VALUE_W-1:0]  fin_value;
  logic                         res_valid;
  logic [adp_pkg::STATUS_W-1:0] res_status;
  logic [adp_pkg::VALUE_W-1:0]  res_value;
  logic                         cfg_wr;

  // ---------------- configuration port ----------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tgt_r <= adp_pkg::TT_U8;
    end else if (cfg_wr && paddr[2] == adp_pkg::REG_TARGET_TYPE) begin
      tgt_r <= pwdata[adp_pkg::TYPE_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == adp_pkg::REG_TARGET_TYPE) begin
      prdata[adp_pkg::TYPE_W-1:0] = tgt_r;
    end
  end

  // ---------------- character decode ----------------
  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign in_fire       = in_chan.valid && in_chan.ready;

  assign is_end    = in_chan.at_end || (in_chan.ch == adp_pkg::CH_NUL);
  assign is_digit  = !is_end && (in_chan.ch inside {[adp_pkg::CH_ZERO:adp_pkg::CH_NINE]});
  assign is_space  = (in_chan.ch == adp_pkg::CH_SPACE) || (in_chan.ch == adp_pkg::CH_TAB);
  assign is_sign   = (in_chan.ch == adp_pkg::CH_MINUS) || (in_chan.ch == adp_pkg::CH_PLUS);
  assign digit_val = in_chan.ch[3:0];

  // acc * 10 + d; any bit above the accumulator width means overflow
  assign prod = (PROD_W'(acc_r) << 3) + (PROD_W'(acc_r) << 1) + PROD_W'(digit_val);
  assign ovf  = prod[PROD_W-1:ACC_BITS] != '0;

  // ---------------- range check of the finished number ----------------
  assign acc_ext = EXT_W'(acc_r);

  always_comb begin
    fin_status = adp_pkg::ST_OK;
    fin_value  = acc_ext[adp_pkg::VALUE_W-1:0];
    case (tgt_r)
      adp_pkg::TT_U8: begin
        if (neg_r || acc_ext > EXT_W'(32'hFF)) begin
          fin_status = adp_pkg::ST_RANGE;
        end
      end
      adp_pkg::TT_U32: begin
        if (neg_r || acc_ext > EXT_W'(32'hFFFF_FFFF)) begin
          fin_status = adp_pkg::ST_RANGE;
        end
      end
      default: begin
        if (neg_r) begin
          if (acc_ext > EXT_W'(32'd32768)) begin
            fin_status = adp_pkg::ST_RANGE;
          end else begin
            fin_value = ~acc_ext[adp_pkg::VALUE_W-1:0] + adp_pkg::VALUE_W'(1);
          end
        end else if (acc_ext > EXT_W'(32'd32767)) begin
          fin_status = adp_pkg::ST_RANGE;
        end
      end
    endcase
  end

  // ---------------- next state ----------------
  always_comb begin
    phase_nxt  = phase_r;
    neg_nxt    = neg_r;
    acc_nxt    = acc_r;
    res_valid  = 1'b0;
    res_status = adp_pkg::ST_OK;
    res_value  = '0;
    case (phase_r)
      adp_pkg::PH_DIGITS: begin
        if (is_digit) begin
          if (ovf) begin
            res_valid  = 1'b1;
            res_status = adp_pkg::ST_OVERFLOW;
          end else begin
            acc_nxt = prod[ACC_BITS-1:0];
          end
        end else begin
          res_valid  = 1'b1;
          res_status = fin_status;
          res_value  = fin_value;
        end
      end
      adp_pkg::PH_SIGN: begin
        if (is_digit) begin
          acc_nxt   = ACC_BITS'(digit_val);
          phase_nxt = adp_pkg::PH_DIGITS;
        end else begin
          res_valid  = 1'b1;
          res_status = adp_pkg::ST_NODIGIT;
        end
      end
      default: begin
        if (is_end) begin
          res_valid  = 1'b1;
          res_status = adp_pkg::ST_NOSTART;
        end else if (is_space) begin
          phase_nxt = adp_pkg::PH_SEEK;
        end else if (is_sign) begin
          neg_nxt   = (in_chan.ch == adp_pkg::CH_MINUS);
          acc_nxt   = '0;
          phase_nxt = adp_pkg::PH_SIGN;
        end else if (is_digit) begin
          neg_nxt   = 1'b0;
          acc_nxt   = ACC_BITS'(digit_val);
          phase_nxt = adp_pkg::PH_DIGITS;
        end else begin
          res_valid  = 1'b1;
          res_status = adp_pkg::ST_NOSTART;
        end
      end
    endcase

    if (res_status != adp_pkg::ST_OK) begin
      res_value = '0;
    end

    // every result drops back to seeking
    if (res_valid) begin
      phase_nxt = adp_pkg::PH_SEEK;
      neg_nxt   = 1'b0;
      acc_nxt   = '0;
    end

    failures_nxt = failures_r;
    if (res_valid && res_status != adp_pkg::ST_OK && failures_r != adp_pkg::FAIL_MAX) begin
      failures_nxt = failures_r + adp_pkg::FAIL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= adp_pkg::PH_SEEK;
      neg_r      <= 1'b0;
      acc_r      <= '0;
      failures_r <= '0;
    end else if (in_fire) begin
      phase_r    <= phase_nxt;
      neg_r      <= neg_nxt;
      acc_r      <= acc_nxt;
      failures_r <= failures_nxt;
    end
  end

  // ---------------- result register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire && res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && res_valid) begin
      value_r    <= res_value;
      status_r   <= res_status;
      fail_cnt_r <= failures_nxt;
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.value      = value_r;
  assign out_chan.status     = status_r;
  assign out_chan.fail_count = fail_cnt_r;

  // ---------------- assertions ----------------
  `ADP_ASSERT_IMPLY(a_err_value_zero, clk, rst_n, out_valid_r && status_r != adp_pkg::ST_OK, value_r == '0, "error result carries a nonzero value")
  `ADP_ASSERT_IMPLY(a_seek_clean, clk, rst_n, phase_r == adp_pkg::PH_SEEK, acc_r == '0 && !neg_r, "seeking with stale accumulator or sign")
  `ADP_ASSERT(a_fail_inc, clk, rst_n, in_fire && res_valid && res_status != adp_pkg::ST_OK && failures_r != adp_pkg::FAIL_MAX |=> failures_r == $past(failures_r) + adp_pkg::FAIL_W'(1), "failure count did not advance")

endmodule

@@ sim/ascii_decimal_number_parser_test.sv @@
`timescale 1ns / 1ps
// Self-checking bench for ascii_decimal_number_parser: character words in, result words out.
// Needs adp_pkg, adp_if and the parser RTL; a scoreboard class predicts every result word.
module ascii_decimal_number_parser_test;

  localparam int ACC_W          = 32;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int LONG_HOLD      = 120;
  localparam int RANDOM_CHARS   = 1200;
  localparam int PHASE_CHARS    = 150;
  localparam int DRAIN_CYCLES   = 8;
  localparam int EXTRA_FAILS    = 40;

  // code 3 is not a documented type; the parser treats it as signed 16-bit
  localparam logic [adp_pkg::TYPE_W-1:0] TT_SPARE  = 2'd3;
  localparam logic [adp_pkg::CFG_AW-1:0] TYPE_ADDR = {adp_pkg::REG_TARGET_TYPE, 2'b00};

  typedef struct {
    logic [adp_pkg::VALUE_W-1:0]  value;
    logic [adp_pkg::STATUS_W-1:0] status;
    logic [adp_pkg::FAIL_W-1:0]   fails;
  } parse_word_t;

  class number_scoreboard;
    logic [adp_pkg::PHASE_W-1:0] phase;
    logic                        negative;
    logic [ACC_W-1:0]            acc;
    logic [adp_pkg::FAIL_W-1:0]  fails;
    logic [adp_pkg::TYPE_W-1:0]  target;
    parse_word_t                 expected_words[$];
    int                          mismatches;
    int                          chars_noted;
    int                          words_checked;
    int                          status_count[5];

    function new();
      phase = adp_pkg::PH_SEEK;
      negative = 1'b0;
      acc = '0;
      fails = '0;
      target = adp_pkg::TT_U8;
      mismatches = 0;
      chars_noted = 0;
      words_checked = 0;
      foreach (status_count[i]) status_count[i] = 0;
    endfunction

    function void report(string what);
      if (mismatches < 10) $display("mismatch: %s", what);
      mismatches++;
    endfunction

    function int pending();
      return expected_words.size();
    endfunction

    // queue one result word and go back to seeking
    function void push_word(logic [adp_pkg::STATUS_W-1:0] status,
                            logic [adp_pkg::VALUE_W-1:0] value);
      parse_word_t w;
      if (status != adp_pkg::ST_OK && fails != adp_pkg::FAIL_MAX) fails++;
      w.value = (status == adp_pkg::ST_OK) ? value : '0;
      w.status = status;
      w.fails = fails;
      expected_words.push_back(w);
      phase = adp_pkg::PH_SEEK;
      negative = 1'b0;
      acc = '0;
    endfunction

    function void close_number();
      logic [adp_pkg::VALUE_W-1:0] mag;
      mag = adp_pkg::VALUE_W'(acc);
      case (target)
        adp_pkg::TT_U8: begin
          if (negative || acc > 255) push_word(adp_pkg::ST_RANGE, '0);
          else push_word(adp_pkg::ST_OK, mag);
        end
        adp_pkg::TT_U32: begin
          if (negative || acc > 64'hFFFF_FFFF) push_word(adp_pkg::ST_RANGE, '0);
          else push_word(adp_pkg::ST_OK, mag);
        end
        default: begin
          if (negative) begin
            if (acc > 32768) push_word(adp_pkg::ST_RANGE, '0);
            else push_word(adp_pkg::ST_OK, -mag);
          end else if (acc > 32767) begin
            push_word(adp_pkg::ST_RANGE, '0);
          end else begin
            push_word(adp_pkg::ST_OK, mag);
          end
        end
      endcase
    endfunction

    function void note_char(logic [adp_pkg::CH_W-1:0] c, logic at_end);
      logic             term;
      logic             is_digit;
      logic [3:0]       d;
      logic [ACC_W+4:0] grown;
      chars_noted++;
      term = at_end || c == adp_pkg::CH_NUL;
      is_digit = !term && c >= adp_pkg::CH_ZERO && c <= adp_pkg::CH_NINE;
      d = is_digit ? 4'(c - adp_pkg::CH_ZERO) : 4'd0;
      case (phase)
        adp_pkg::PH_DIGITS: begin
          if (!is_digit) begin
            close_number();
          end else begin
            grown = {5'b0, acc} * 10 + d;
            // the digit that overflows is consumed and ends the number
            if (grown > {ACC_W{1'b1}}) push_word(adp_pkg::ST_OVERFLOW, '0);
            else acc = grown[ACC_W-1:0];
          end
        end
        adp_pkg::PH_SIGN: begin
          if (is_digit) begin
            acc = ACC_W'(d);
            phase = adp_pkg::PH_DIGITS;
          end else begin
            push_word(adp_pkg::ST_NODIGIT, '0);
          end
        end
        default: begin
          if (term) begin
            push_word(adp_pkg::ST_NOSTART, '0);
          end else if (c == adp_pkg::CH_SPACE || c == adp_pkg::CH_TAB) begin
            phase = adp_pkg::PH_SEEK;
          end else if (c == adp_pkg::CH_MINUS || c == adp_pkg::CH_PLUS) begin
            negative = (c == adp_pkg::CH_MINUS);
            acc = '0;
            phase = adp_pkg::PH_SIGN;
          end else if (is_digit) begin
            negative = 1'b0;
            acc = ACC_W'(d);
            phase = adp_pkg::PH_DIGITS;
          end else begin
            push_word(adp_pkg::ST_NOSTART, '0);
          end
        end
      endcase
    endfunction

    function void check_word(logic [adp_pkg::VALUE_W-1:0] value,
                             logic [adp_pkg::STATUS_W-1:0] status,
                             logic [adp_pkg::FAIL_W-1:0] fail_count);
      parse_word_t w;
      if (expected_words.size() == 0) begin
        report($sformatf("unexpected word value %0d status %0d fails %0d",
                         $signed(value), status, fail_count));
        return;
      end
      w = expected_words.pop_front();
      words_checked++;
      status_count[w.status]++;
      if (value !== w.value || status !== w.status || fail_count !== w.fails)
        report($sformatf({"expected value %0d status %0d fails %0d, ",
                          "got value %0d status %0d fails %0d"},
                         $signed(w.value), w.status, w.fails,
                         $signed(value), status, fail_count));
    endfunction

    function void close_out();
      if (expected_words.size() != 0)
        report($sformatf("%0d result words never arrived", expected_words.size()));
    endfunction
  endclass

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       psel;
  logic                       penable;
  logic                       pwrite;
  logic [adp_pkg::CFG_AW-1:0] paddr;
  logic [adp_pkg::CFG_DW-1:0] pwdata;
  logic [adp_pkg::CFG_DW-1:0] prdata;
  logic                       pready;

  adp_in_if  in_if();
  adp_out_if out_if();

  number_scoreboard sb = new();

  bit tx_eager;
  bit rx_eager;
  bit rx_hold_req;
  int chars_sent;
  int types_written;
  int idle_cycles;

  ascii_decimal_number_parser #(.ACC_BITS(ACC_W)) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_if),
    .out_chan(out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_if.valid && out_if.ready)
        sb.check_word(out_if.value, out_if.status, out_if.fail_count);
      if (in_if.valid && in_if.ready)
        sb.note_char(in_if.ch, in_if.at_end);
      if ((out_if.valid && out_if.ready) || (in_if.valid && in_if.ready) ||
          (psel && penable && pready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
        $display("ascii_decimal_number_parser_test NOT OK");
        $finish;
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(16, 40);
  endfunction

  // result side: random stalls, plus one long hold-off on request
  initial begin : drain_results
    int stall_left;
    stall_left = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        stall_left = LONG_HOLD;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else if (rx_eager || $urandom_range(0, 99) < 70) begin
        out_if.ready <= 1'b1;
      end else begin
        stall_left = pick_gap() - 1;
        out_if.ready <= 1'b0;
      end
    end
  end

  task automatic send_char(input logic [adp_pkg::CH_W-1:0] c, input logic at_end);
    int gap;
    gap = (tx_eager || $urandom_range(0, 99) < 65) ? 0 : pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_if.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_if.valid <= 1'b1;
    in_if.ch <= c;
    in_if.at_end <= at_end;
    do @(posedge clk); while (!in_if.ready);
    chars_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], 1'b0);
  endtask

  task automatic drop_input();
    @(negedge clk);
    in_if.valid <= 1'b0;
  endtask

  // hold the input until every expected word is out, then let the block go quiet
  task automatic settle();
    drop_input();
    while (sb.pending() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic apb_access(input logic wr, input logic [adp_pkg::CFG_DW-1:0] wdata,
                            output logic [adp_pkg::CFG_DW-1:0] rdata);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= TYPE_ADDR;
    pwdata <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_target_type(input logic [adp_pkg::TYPE_W-1:0] tt);
    logic [adp_pkg::CFG_DW-1:0] rd;
    apb_access(1'b1, {(adp_pkg::CFG_DW-adp_pkg::TYPE_W)'($urandom()), tt}, rd);
    sb.target = tt;
    types_written++;
    apb_access(1'b0, '0, rd);
    if (rd[adp_pkg::TYPE_W-1:0] !== tt)
      sb.report($sformatf("target_type reads %0d after writing %0d",
                          rd[adp_pkg::TYPE_W-1:0], tt));
  endtask

  function automatic longint unsigned pick_magnitude();
    case ($urandom_range(0, 7))
      0: return $urandom_range(0, 9);
      1: return 64'd254 + $urandom_range(0, 2);
      2: return 64'd32766 + $urandom_range(0, 3);
      3: return 64'd4294967294 + $urandom_range(0, 2);
      4: return {$urandom(), $urandom()};
      5: return $urandom();
      6: return $urandom_range(0, 70000);
      default: return $urandom_range(0, 1000);
    endcase
  endfunction

  function automatic logic [adp_pkg::CH_W-1:0] pick_non_digit();
    logic [adp_pkg::CH_W-1:0] c;
    if ($urandom_range(0, 4) == 0) return adp_pkg::CH_NUL;
    do c = adp_pkg::CH_W'($urandom_range(0, 255));
    while (c >= adp_pkg::CH_ZERO && c <= adp_pkg::CH_NINE);
    return c;
  endfunction

  function automatic logic [adp_pkg::CH_W-1:0] pick_nonstart();
    logic [adp_pkg::CH_W-1:0] c;
    do c = adp_pkg::CH_W'($urandom_range(0, 255));
    while ((c >= adp_pkg::CH_ZERO && c <= adp_pkg::CH_NINE) ||
           c == adp_pkg::CH_SPACE || c == adp_pkg::CH_TAB ||
           c == adp_pkg::CH_MINUS || c == adp_pkg::CH_PLUS);
    return c;
  endfunction

  task automatic send_terminator();
    if ($urandom_range(0, 4) == 0) send_char(adp_pkg::CH_W'($urandom_range(0, 255)), 1'b1);
    else send_char(pick_non_digit(), 1'b0);
  endtask

  task automatic send_number();
    string digits;
    int    n_ws;
    n_ws = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
    repeat (n_ws) send_char($urandom_range(0, 1) ? adp_pkg::CH_SPACE : adp_pkg::CH_TAB, 1'b0);
    case ($urandom_range(0, 3))
      0: send_char(adp_pkg::CH_MINUS, 1'b0);
      1: send_char(adp_pkg::CH_PLUS, 1'b0);
      default: ;
    endcase
    digits = $sformatf("%0d", pick_magnitude());
    if ($urandom_range(0, 4) == 0) repeat ($urandom_range(1, 12)) digits = {"0", digits};
    send_text(digits);
    send_terminator();
  endtask

  // sign with no digit behind it
  task automatic send_broken();
    send_char($urandom_range(0, 1) ? adp_pkg::CH_MINUS : adp_pkg::CH_PLUS, 1'b0);
    case ($urandom_range(0, 2))
      0: send_char($urandom_range(0, 1) ? adp_pkg::CH_SPACE : adp_pkg::CH_TAB, 1'b0);
      1: send_char($urandom_range(0, 1) ? adp_pkg::CH_MINUS : adp_pkg::CH_PLUS, 1'b0);
      default: send_terminator();
    endcase
  endtask

  task automatic send_failure();
    if ($urandom_range(0, 3) == 0) send_char(adp_pkg::CH_W'($urandom_range(0, 255)), 1'b1);
    else send_char(pick_nonstart(), 1'b0);
  endtask

  initial begin
    int phase_no;
    int start_chars;
    int r;
    in_if.valid = 1'b0;
    in_if.ch = '0;
    in_if.at_end = 1'b0;
    out_if.ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    tx_eager = 1'b0;
    rx_eager = 1'b0;
    rx_hold_req = 1'b0;
    chars_sent = 0;
    types_written = 0;
    idle_cycles = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: whitespace skip, -0 on unsigned, sign without digits, bad lead, end mark,
    // one past the 32-bit limit
    send_text(" \t255");
    send_char(adp_pkg::CH_NUL, 1'b0);
    send_text("-0");
    send_char(adp_pkg::CH_NINE, 1'b1);
    send_text("+ ");
    send_char(8'hFF, 1'b0);
    send_char(adp_pkg::CH_NINE, 1'b1);
    send_text("4294967296");

    phase_no = 0;
    start_chars = chars_sent;
    while (chars_sent - start_chars < RANDOM_CHARS) begin
      settle();
      case (phase_no)
        0: set_target_type(adp_pkg::TT_S16);
        1: set_target_type(adp_pkg::TT_U32);
        2: set_target_type(TT_SPARE);
        3: set_target_type(adp_pkg::TT_U8);
        default: set_target_type(adp_pkg::TYPE_W'($urandom_range(0, 3)));
      endcase
      rx_eager = (phase_no % 3 == 0);
      tx_eager = (phase_no % 4 == 2) || (phase_no % 3 == 1);
      // fill the block while the result side holds off
      if (phase_no % 3 == 1) rx_hold_req = 1'b1;
      r = chars_sent;
      while (chars_sent - r < PHASE_CHARS) begin
        case ($urandom_range(0, 99)) inside
          [0:69]:  send_number();
          [70:79]: send_broken();
          [80:97]: send_char(adp_pkg::CH_W'($urandom_range(0, 255)),
                             $urandom_range(0, 9) == 0);
          default: begin
            drop_input();
            while (sb.pending() != 0) @(negedge clk);
          end
        endcase
      end
      phase_no++;
    end

    // back-to-back failures around the signed 16-bit minimum
    settle();
    set_target_type(adp_pkg::TT_S16);
    tx_eager = 1'b1;
    rx_eager = 1'b1;
    repeat (EXTRA_FAILS) send_failure();
    send_text("-32768");
    send_char(adp_pkg::CH_NUL, 1'b0);
    send_failure();
    tx_eager = 1'b0;
    rx_eager = 1'b0;

    settle();
    sb.close_out();
    $display("covered %0d characters, %0d result words, %0d target_type writes",
             sb.chars_noted, sb.words_checked, types_written);
    $display("words by status: ok %0d, no start %0d, no digits %0d, overflow %0d, range %0d",
             sb.status_count[adp_pkg::ST_OK], sb.status_count[adp_pkg::ST_NOSTART],
             sb.status_count[adp_pkg::ST_NODIGIT], sb.status_count[adp_pkg::ST_OVERFLOW],
             sb.status_count[adp_pkg::ST_RANGE]);
    if (sb.mismatches == 0)
      $display("ascii_decimal_number_parser_test OK");
    else
      $display("ascii_decimal_number_parser_test NOT OK");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/adp_pkg.sv
rtl/core/adp_if.sv
rtl/core/ascii_decimal_number_parser.sv
sim/ascii_decimal_number_parser_test.sv
